[design/lrs_pkg.sv]
`default_nettype none

package lrs_pkg;

    // Request kinds carried on the input tuser
    localparam logic [1:0] REQ_POLL     = 2'd0;
    localparam logic [1:0] REQ_RX_START = 2'd1;
    localparam logic [1:0] REQ_TX_START = 2'd2;
    localparam logic [1:0] REQ_IDLE     = 2'd3;

    // Status codes reported with every result
    localparam logic [2:0] STAT_IDLE       = 3'd0;
    localparam logic [2:0] STAT_BUSY       = 3'd1;
    localparam logic [2:0] STAT_WAIT_SIG   = 3'd2;
    localparam logic [2:0] STAT_RX_RUNNING = 3'd3;
    localparam logic [2:0] STAT_RX_DONE    = 3'd4;
    localparam logic [2:0] STAT_RX_TIMEOUT = 3'd5;
    localparam logic [2:0] STAT_TX_DONE    = 3'd6;

    // Interrupt flag to clear
    localparam logic [1:0] CLR_NONE    = 2'd0;
    localparam logic [1:0] CLR_HEADER  = 2'd1;
    localparam logic [1:0] CLR_RX_DONE = 2'd2;
    localparam logic [1:0] CLR_TX_DONE = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_RX_SINGLE   = 2'd0;
    localparam logic [1:0] CFG_IMPLICIT    = 2'd1;
    localparam logic [1:0] CFG_FIXED_LEN   = 2'd2;
    localparam logic [1:0] CFG_RX_TIMEOUT  = 2'd3;

    // Configuration reset values
    localparam logic [7:0]  FIXED_LEN_RESET  = 8'd8;
    localparam logic [15:0] RX_TIMEOUT_RESET = 16'd3000;

    // RSSI offset in dBm
    localparam logic signed [9:0] RSSI_BASE = -10'sd164;

    // Port widths
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 64;
    localparam int CFG_DATA_W = 16;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  tx_length;
        logic [31:0] now_ms;
        logic        done_line;
        logic        header_line;
        logic        crc_error;
        logic [7:0]  snr_raw;
        logic [7:0]  rssi_raw;
        logic [7:0]  rx_byte_count;
    } req_t;

    typedef struct packed {
        logic [2:0]        status;
        logic              do_rx_setup;
        logic              do_tx_send;
        logic [1:0]        clear_flag;
        logic              read_packet;
        logic [7:0]        packet_size;
        logic signed [5:0] snr_quarter;
        logic signed [8:0] rssi_dbm;
        logic [31:0]       packet_time_ms;
    } res_t;

endpackage

`default_nettype wire

[design/lora_radio_rx_tx_sequencer_top.sv]
`default_nettype none

// LoRa receive/transmit sequencer.
// Input stream: one command or poll per transfer. s_tuser carries the request
// kind (poll, start receive, start transmit, force idle), s_tdata the rest.
// Output stream: one result per input transfer, in order, carrying status,
// radio actions, flag to clear, packet size, SNR, RSSI and packet time.
// Configuration: cfg_we/cfg_index/cfg_data write the four mode registers;
// write them only while no item is in flight.
// Throughput: one item per cycle while m_tready stays high. An accepted item is
// registered in the input register, evaluated against the sequencer state there
// and registered in the result register, which drives m_tvalid.
// Stall: while m_tready is low the result register holds; the input
// register still takes one more item, after which s_tready drops until the
// result is taken.
// Reset (rst_n low): state idle, times and sizes zero, registers at their
// defaults (continuous receive, explicit header, length 8, timeout 3000 ms),
// both pipeline registers empty.
module lora_radio_rx_tx_sequencer_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Input stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // tdata: tx_length[7:0], now_ms[39:8], done_line[40], header_line[41],
    //        crc_error[42], snr_raw[50:43], rssi_raw[58:51],
    //        rx_byte_count[66:59], zero[71:67]
    input  wire logic [lrs_pkg::IN_DATA_W-1:0]   s_tdata,
    // tuser: req_type[1:0]
    input  wire logic [1:0]                      s_tuser,
    // Output stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // tdata: status[2:0], do_rx_setup[3], do_tx_send[4], clear_flag[6:5],
    //        read_packet[7], packet_size[15:8], snr_quarter[21:16],
    //        rssi_dbm[30:22], packet_time_ms[62:31], zero[63]
    output logic [lrs_pkg::OUT_DATA_W-1:0]       m_tdata,
    // Configuration write port
    input  wire logic                            cfg_we,
    input  wire logic [1:0]                      cfg_index,
    input  wire logic [lrs_pkg::CFG_DATA_W-1:0]  cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE        = 4'd0,
        ST_RX_INIT     = 4'd1,
        ST_WAIT_SIGNAL = 4'd2,
        ST_RX_RUNNING  = 4'd3,
        ST_RX_DONE     = 4'd4,
        ST_RX_TIMEOUT  = 4'd5,
        ST_TX_INIT     = 4'd6,
        ST_TX_RUNNING  = 4'd7,
        ST_TX_DONE     = 4'd8
    } state_t;

    // Configuration registers
    logic        rx_single_reg;
    logic        implicit_reg;
    logic [7:0]  fixed_len_reg;
    logic [15:0] rx_timeout_reg;

    // Sequencer state
    state_t      state_reg, state_next;
    logic [31:0] start_time_reg, start_time_next;
    logic [7:0]  tx_size_reg, tx_size_next;
    logic [31:0] last_time_reg, last_time_next;

    // Pipeline registers
    logic           in_valid_reg;
    lrs_pkg::req_t  in_reg;
    logic           out_valid_reg;
    lrs_pkg::res_t  out_reg;

    lrs_pkg::req_t  req_in;
    lrs_pkg::res_t  res;
    logic           advance;

    logic [31:0]       elapsed;
    logic [7:0]        snr_abs;
    logic [5:0]        snr_mag;
    logic signed [6:0] snr_val;
    logic signed [9:0] rssi_val;
    logic [7:0]        tx_len_cut;

    // Unpack the input transfer
    assign req_in.req_type      = s_tuser;
    assign req_in.tx_length     = s_tdata[7:0];
    assign req_in.now_ms        = s_tdata[39:8];
    assign req_in.done_line     = s_tdata[40];
    assign req_in.header_line   = s_tdata[41];
    assign req_in.crc_error     = s_tdata[42];
    assign req_in.snr_raw       = s_tdata[50:43];
    assign req_in.rssi_raw      = s_tdata[58:51];
    assign req_in.rx_byte_count = s_tdata[66:59];

    // Evaluate when the result register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // SNR in whole dB, truncated toward zero
    assign snr_abs = in_reg.snr_raw[7] ? (8'd0 - in_reg.snr_raw) : in_reg.snr_raw;
    assign snr_mag = snr_abs[7:2];
    assign snr_val = in_reg.snr_raw[7] ? -$signed({1'b0, snr_mag})
                                       : $signed({1'b0, snr_mag});

    // RSSI with offset and SNR or high-nibble correction
    always_comb
    begin
        if (snr_val < 0)
            rssi_val = lrs_pkg::RSSI_BASE + $signed({2'b00, in_reg.rssi_raw})
                       + 10'(snr_val);
        else
            rssi_val = lrs_pkg::RSSI_BASE + $signed({2'b00, in_reg.rssi_raw})
                       + $signed({6'd0, in_reg.rssi_raw[7:4]});
    end

    assign elapsed    = in_reg.now_ms - start_time_reg;
    assign tx_len_cut = (implicit_reg && (fixed_len_reg < in_reg.tx_length))
                        ? fixed_len_reg : in_reg.tx_length;

    // Next state and result of the item in the input register
    always_comb
    begin
        state_next      = state_reg;
        start_time_next = start_time_reg;
        tx_size_next    = tx_size_reg;
        last_time_next  = last_time_reg;

        res             = '0;
        res.status      = lrs_pkg::STAT_BUSY;
        res.clear_flag  = lrs_pkg::CLR_NONE;

        unique case (in_reg.req_type)
            lrs_pkg::REQ_RX_START:
            begin
                state_next = ST_RX_INIT;
            end
            lrs_pkg::REQ_TX_START:
            begin
                tx_size_next = tx_len_cut;
                state_next   = ST_TX_INIT;
            end
            lrs_pkg::REQ_IDLE:
            begin
                state_next = ST_IDLE;
                res.status = lrs_pkg::STAT_IDLE;
            end
            default:
            begin
                unique case (state_reg)
                    ST_IDLE:
                    begin
                        res.status = lrs_pkg::STAT_IDLE;
                    end
                    ST_RX_INIT:
                    begin
                        res.do_rx_setup = 1'b1;
                        state_next      = ST_WAIT_SIGNAL;
                        start_time_next = in_reg.now_ms;
                    end
                    ST_WAIT_SIGNAL:
                    begin
                        if (in_reg.header_line)
                        begin
                            state_next     = ST_RX_RUNNING;
                            res.clear_flag = lrs_pkg::CLR_HEADER;
                        end
                        res.status = lrs_pkg::STAT_WAIT_SIG;
                    end
                    ST_RX_RUNNING:
                    begin
                        if (in_reg.done_line)
                        begin
                            last_time_next = elapsed;
                            res.clear_flag = lrs_pkg::CLR_RX_DONE;
                            state_next     = ST_RX_DONE;
                        end
                        // Timeout wins over a done seen in the same poll
                        if (rx_single_reg && (elapsed > {16'd0, rx_timeout_reg}))
                        begin
                            last_time_next = elapsed;
                            state_next     = ST_RX_TIMEOUT;
                        end
                        res.status = lrs_pkg::STAT_RX_RUNNING;
                    end
                    ST_RX_DONE:
                    begin
                        start_time_next = in_reg.now_ms;
                        if (in_reg.crc_error)
                        begin
                            // Drop the packet
                            state_next = rx_single_reg ? ST_IDLE : ST_RX_RUNNING;
                        end
                        else
                        begin
                            res.clear_flag  = lrs_pkg::CLR_RX_DONE;
                            res.snr_quarter = snr_val[5:0];
                            res.rssi_dbm    = rssi_val[8:0];
                            res.packet_size = implicit_reg ? fixed_len_reg
                                                           : in_reg.rx_byte_count;
                            res.read_packet = 1'b1;
                            state_next      = rx_single_reg ? ST_IDLE : ST_WAIT_SIGNAL;
                            res.status      = lrs_pkg::STAT_RX_DONE;
                        end
                    end
                    ST_RX_TIMEOUT:
                    begin
                        state_next = ST_IDLE;
                        res.status = lrs_pkg::STAT_RX_TIMEOUT;
                    end
                    ST_TX_INIT:
                    begin
                        res.do_tx_send  = 1'b1;
                        res.packet_size = tx_size_reg;
                        state_next      = ST_TX_RUNNING;
                        start_time_next = in_reg.now_ms;
                    end
                    ST_TX_RUNNING:
                    begin
                        if (in_reg.done_line)
                        begin
                            last_time_next = elapsed;
                            res.clear_flag = lrs_pkg::CLR_TX_DONE;
                            state_next     = ST_TX_DONE;
                        end
                    end
                    ST_TX_DONE:
                    begin
                        state_next = rx_single_reg ? ST_IDLE : ST_RX_INIT;
                        res.status = lrs_pkg::STAT_TX_DONE;
                    end
                    default:
                    begin
                        // Unused codes report busy and hold
                    end
                endcase
            end
        endcase

        res.packet_time_ms = last_time_next;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_single_reg  <= 1'b0;
            implicit_reg   <= 1'b0;
            fixed_len_reg  <= lrs_pkg::FIXED_LEN_RESET;
            rx_timeout_reg <= lrs_pkg::RX_TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lrs_pkg::CFG_RX_SINGLE:  rx_single_reg  <= cfg_data[0];
                lrs_pkg::CFG_IMPLICIT:   implicit_reg   <= cfg_data[0];
                lrs_pkg::CFG_FIXED_LEN:  fixed_len_reg  <= cfg_data[7:0];
                lrs_pkg::CFG_RX_TIMEOUT: rx_timeout_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer state, pipeline control and payload registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            start_time_reg <= '0;
            tx_size_reg    <= '0;
            last_time_reg  <= '0;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            in_reg         <= '0;
            out_reg        <= '0;
        end
        else
        begin
            if (advance)
            begin
                state_reg      <= state_next;
                start_time_reg <= start_time_next;
                tx_size_reg    <= tx_size_next;
                last_time_reg  <= last_time_next;
                out_reg        <= res;
            end
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (s_tvalid && s_tready)
                in_reg <= req_in;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Pack the result transfer
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0,
                       out_reg.packet_time_ms,
                       out_reg.rssi_dbm,
                       out_reg.snr_quarter,
                       out_reg.packet_size,
                       out_reg.read_packet,
                       out_reg.clear_flag,
                       out_reg.do_tx_send,
                       out_reg.do_rx_setup,
                       out_reg.status};

    // Receive setup always moves the sequencer on to wait for a header
    a_rx_setup_next: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res.do_rx_setup) |=> (state_reg == ST_WAIT_SIGNAL))
        else $error("receive setup did not lead to wait_signal");

    // A packet read only comes with the rx-done status
    a_read_status: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res.read_packet) |-> (res.status == lrs_pkg::STAT_RX_DONE))
        else $error("packet read without rx-done status");

    // At most one radio action per result
    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> $onehot0({res.do_rx_setup, res.do_tx_send, res.read_packet}))
        else $error("more than one radio action in one result");

    // A result is written only from a full input register
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(out_valid_reg)) |-> $past(in_valid_reg))
        else $error("result appeared without an input item");

endmodule

`default_nettype wire
